>>> rtl/jqte_pkg.sv
// ----------------------------------------------------------------------------
// jqte_pkg
// shared types, codes and constants for the job queue table engine
// ----------------------------------------------------------------------------
package jqte_pkg;

   localparam int QueueDepthDefault = 16;

   localparam logic [3:0] MODE_ADD     = 4'd0;
   localparam logic [3:0] MODE_REMOVE  = 4'd1;
   localparam logic [3:0] MODE_MODIFY  = 4'd2;
   localparam logic [3:0] MODE_CHANGE  = 4'd3;
   localparam logic [3:0] MODE_PROMOTE = 4'd4;
   localparam logic [3:0] MODE_REORDER = 4'd5;
   localparam logic [3:0] MODE_COUNT   = 4'd6;
   localparam logic [3:0] MODE_DISPLAY = 4'd7;
   localparam logic [3:0] MODE_LIST    = 4'd8;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_BAD_FIELD = 3'd5;
   localparam logic [2:0] ST_BAD_MODE  = 3'd6;

   localparam logic [2:0] ATTR_ID   = 3'd1;
   localparam logic [2:0] ATTR_PRIO = 3'd2;
   localparam logic [2:0] ATTR_KIND = 3'd3;
   localparam logic [2:0] ATTR_CPU  = 3'd4;
   localparam logic [2:0] ATTR_MEM  = 3'd5;

   localparam logic [2:0] FLD_PRIO = 3'd1;
   localparam logic [2:0] FLD_KIND = 3'd2;
   localparam logic [2:0] FLD_CPU  = 3'd3;
   localparam logic [2:0] FLD_MEM  = 3'd4;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  prio;
      logic [3:0]  kind;
      logic [15:0] cpu;
      logic [15:0] mem;
   } job_rec_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] job_key;
      logic [3:0]  prio_in;
      logic [3:0]  kind_in;
      logic [15:0] cpu_in;
      logic [15:0] mem_in;
      logic [2:0]  field_pick;
      logic [15:0] new_field_value;
      logic [6:0]  move_ahead;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] job_out;
      logic [3:0]  prio_out;
      logic [3:0]  kind_out;
      logic [15:0] cpu_out;
      logic [15:0] mem_out;
      logic [6:0]  occupancy;
      logic        last;
   } rsp_type;

   function automatic logic [15:0] attr_of(job_rec_type r, logic [2:0] a);
      logic [15:0] v;
      case (a)
         ATTR_ID:   v = r.id;
         ATTR_PRIO: v = {12'd0, r.prio};
         ATTR_KIND: v = {12'd0, r.kind};
         ATTR_CPU:  v = r.cpu;
         default:   v = r.mem;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/jqte_if.sv
// ----------------------------------------------------------------------------
// jqte_req_if / jqte_rsp_if
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface jqte_req_if import jqte_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface jqte_rsp_if import jqte_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/jqte_mem.sv
// ----------------------------------------------------------------------------
// jqte_mem
// job record store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module jqte_mem import jqte_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   localparam int AW = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  job_rec_type   wr_data,
   input  logic [AW-1:0] rd_addr,
   output job_rec_type   rd_data
);
   job_rec_type store [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data <= store[rd_addr];
   end
endmodule

>>> rtl/jqte_ctrl.sv
// ----------------------------------------------------------------------------
// jqte_ctrl
// command sequencer: scans, shifts and sorts the store one access a cycle
// ----------------------------------------------------------------------------
module jqte_ctrl import jqte_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   jqte_req_if.sink      req,
   jqte_rsp_if.source    rsp,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output job_rec_type   wr_data,
   output logic [AW-1:0] rd_addr,
   input  job_rec_type   rd_data
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FIND  = 4'd1;
   localparam logic [3:0] S_FOUND = 4'd2;
   localparam logic [3:0] S_POP   = 4'd3;
   localparam logic [3:0] S_SHIFT = 4'd4;
   localparam logic [3:0] S_PROM  = 4'd5;
   localparam logic [3:0] S_SORTA = 4'd6;
   localparam logic [3:0] S_SORTB = 4'd7;
   localparam logic [3:0] S_DUMP  = 4'd8;
   localparam logic [3:0] S_MIN   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_WAIT  = 4'd11;
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   logic [3:0]    state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // scan index
   logic [CW-1:0] pos_ff, pos_in;     // found position
   logic [CW-1:0] dst_ff, dst_in;
   logic [CW-1:0] sorted_ff, sorted_in;
   logic          have_ff, have_in;   // rd_data valid (for idx_ff-1 while scanning)
   job_rec_type   hold_ff, hold_in;
   logic [15:0]   low_ff, low_in;     // last listed id
   logic          first_ff, first_in;
   logic          best_ok_ff, best_ok_in;
   job_rec_type   best_ff, best_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   logic          rv_ff, rv_in;
   rsp_type       rd_ff, rd_in;

   logic [CW-1:0] raddr;
   logic [6:0]    occ;

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   assign rd_addr   = raddr[AW-1:0];
   assign occ       = 7'(count_in);

   function automatic rsp_type mk(logic [2:0] st, job_rec_type j, logic [6:0] o, logic l);
      rsp_type r;
      r.status = st; r.job_out = j.id; r.prio_out = j.prio; r.kind_out = j.kind;
      r.cpu_out = j.cpu; r.mem_out = j.mem; r.occupancy = o; r.last = l;
      return r;
   endfunction

   always_comb begin
      job_rec_type echo, zero, upd, r;
      logic [15:0] ck;
      state_in = state_ff; cmd_in = cmd_ff; count_in = count_ff; idx_in = idx_ff;
      pos_in = pos_ff; dst_in = dst_ff; sorted_in = sorted_ff; have_in = 1'b0;
      hold_in = hold_ff; low_in = low_ff; first_in = first_ff;
      best_ok_in = best_ok_ff; best_in = best_ff; emitted_in = emitted_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = rd_data; raddr = idx_ff;
      zero = '0; echo = '0; echo.id = cmd_ff.job_key;
      upd = rd_data; r = rd_data;
      ck = attr_of(hold_ff, cmd_ff.field_pick);
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            raddr = '0;
            if (req.valid && !rv_ff) begin
               cmd_in = req.data; idx_in = '0; state_in = S_WAIT;
               echo = '0; echo.id = req.data.job_key;
               unique case (req.data.mode) inside
                  MODE_ADD, MODE_MODIFY, MODE_CHANGE, MODE_PROMOTE: begin
                     raddr = '0; idx_in = CW'(1); have_in = (count_ff != 0);
                     state_in = S_FIND;
                  end
                  MODE_REMOVE: begin
                     if (count_ff == 0) begin
                        rv_in = 1'b1; rd_in = mk(ST_EMPTY, zero, occ, 1'b1);
                     end else begin
                        idx_in = CW'(1); state_in = S_POP;
                     end
                  end
                  MODE_REORDER: begin
                     if (count_ff == 0) begin
                        rv_in = 1'b1; rd_in = mk(ST_EMPTY, zero, occ, 1'b1);
                     end else if (req.data.field_pick < ATTR_ID ||
                                  req.data.field_pick > ATTR_MEM) begin
                        rv_in = 1'b1; rd_in = mk(ST_BAD_FIELD, zero, occ, 1'b1);
                     end else begin
                        sorted_in = CW'(1); raddr = CW'(1); state_in = S_SORTA;
                        if (count_ff == CW'(1)) begin
                           rv_in = 1'b1; rd_in = mk(ST_OK, zero, occ, 1'b1);
                           state_in = S_WAIT;
                        end
                     end
                  end
                  MODE_COUNT: begin
                     rv_in = 1'b1; rd_in = mk(ST_OK, zero, occ, 1'b1);
                  end
                  MODE_DISPLAY, MODE_LIST: begin
                     if (count_ff == 0) begin
                        rv_in = 1'b1; rd_in = mk(ST_EMPTY, zero, occ, 1'b1);
                     end else begin
                        emitted_in = '0; first_in = 1'b1; idx_in = '0;
                        state_in = (req.data.mode == MODE_LIST) ? S_MIN : S_DUMP;
                     end
                  end
                  default: begin
                     rv_in = 1'b1; rd_in = mk(ST_BAD_MODE, zero, occ, 1'b1);
                  end
               endcase
            end
         end
         S_FIND: begin
            // rd_data holds entry idx_ff-1 when have_ff
            if (have_ff && rd_data.id == cmd_ff.job_key) begin
               pos_in = idx_ff - CW'(1);
               raddr = idx_ff - CW'(1);
               state_in = S_FOUND;
            end else if (idx_ff >= count_ff || !have_ff) begin
               state_in = S_WAIT; rv_in = 1'b1;
               if (cmd_ff.mode == MODE_ADD) begin
                  if (count_ff == FULL) rd_in = mk(ST_FULL, echo, occ, 1'b1);
                  else begin
                     upd.id = cmd_ff.job_key; upd.prio = cmd_ff.prio_in;
                     upd.kind = cmd_ff.kind_in; upd.cpu = cmd_ff.cpu_in;
                     upd.mem = cmd_ff.mem_in;
                     wr_en = 1'b1; wr_addr = count_ff[AW-1:0]; wr_data = upd;
                     count_in = count_ff + CW'(1);
                     rd_in = mk(ST_OK, upd, 7'(count_ff + CW'(1)), 1'b1);
                  end
               end else rd_in = mk(ST_NOT_FOUND, echo, occ, 1'b1);
            end else begin
               raddr = idx_ff; idx_in = idx_ff + CW'(1); have_in = 1'b1;
            end
         end
         S_FOUND: begin
            // rd_data is the hit, still on the read port
            state_in = S_WAIT; rv_in = 1'b1;
            case (cmd_ff.mode)
               MODE_ADD: rd_in = mk(ST_DUPLICATE, echo, occ, 1'b1);
               MODE_MODIFY: begin
                  upd.prio = cmd_ff.prio_in; upd.kind = cmd_ff.kind_in;
                  upd.cpu = cmd_ff.cpu_in; upd.mem = cmd_ff.mem_in;
                  wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_data = upd;
                  rd_in = mk(ST_OK, upd, occ, 1'b1);
               end
               MODE_CHANGE: begin
                  case (cmd_ff.field_pick)
                     FLD_PRIO: upd.prio = cmd_ff.new_field_value[3:0];
                     FLD_KIND: upd.kind = cmd_ff.new_field_value[3:0];
                     FLD_CPU:  upd.cpu = cmd_ff.new_field_value;
                     FLD_MEM:  upd.mem = cmd_ff.new_field_value;
                     default: ;
                  endcase
                  if (cmd_ff.field_pick >= FLD_PRIO && cmd_ff.field_pick <= FLD_MEM) begin
                     wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_data = upd;
                     rd_in = mk(ST_OK, upd, occ, 1'b1);
                  end else rd_in = mk(ST_BAD_FIELD, echo, occ, 1'b1);
               end
               default: begin
                  hold_in = rd_data;
                  if (7'(pos_ff) > cmd_ff.move_ahead)
                     dst_in = CW'(7'(pos_ff) - cmd_ff.move_ahead);
                  else dst_in = '0;
                  rv_in = 1'b0; state_in = S_PROM; idx_in = pos_ff;
                  raddr = pos_ff - CW'(1);
               end
            endcase
         end
         S_PROM: begin
            // rd_data is entry idx_ff-1; move it up to idx_ff
            if (idx_ff == dst_ff) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = hold_ff;
               rv_in = 1'b1; rd_in = mk(ST_OK, hold_ff, occ, 1'b1); state_in = S_WAIT;
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
               idx_in = idx_ff - CW'(1); raddr = idx_ff - CW'(2);
            end
         end
         S_POP: begin
            // rd_data is entry 0
            hold_in = rd_data; raddr = CW'(1); idx_in = CW'(1); state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // rd_data is entry idx_ff; write to idx_ff-1
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               rv_in = 1'b1; rd_in = mk(ST_OK, hold_ff, 7'(count_ff - CW'(1)), 1'b1);
               state_in = S_WAIT;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(1)); wr_data = rd_data;
               idx_in = idx_ff + CW'(1); raddr = idx_ff + CW'(1);
            end
         end
         S_SORTA: begin
            // rd_data = entry sorted_ff: take it as the key
            hold_in = rd_data; idx_in = sorted_ff; raddr = sorted_ff - CW'(1);
            state_in = S_SORTB;
         end
         S_SORTB: begin
            // rd_data = entry idx_ff-1
            if (idx_ff != 0 && attr_of(rd_data, cmd_ff.field_pick) > ck) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
               idx_in = idx_ff - CW'(1); raddr = idx_ff - CW'(2);
            end else begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = hold_ff;
               sorted_in = sorted_ff + CW'(1); raddr = sorted_ff + CW'(1);
               state_in = S_SORTA;
               if (sorted_ff + CW'(1) >= count_ff) begin
                  rv_in = 1'b1; rd_in = mk(ST_OK, zero, occ, 1'b1); state_in = S_WAIT;
               end
            end
         end
         S_DUMP: begin
            // read idx, output once read data is back and the slot is free
            if (!have_ff) begin
               raddr = idx_ff; have_in = 1'b1;
            end else if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rd_in = mk(ST_OK, rd_data, occ, idx_ff + CW'(1) == count_ff);
               idx_in = idx_ff + CW'(1);
               state_in = (idx_ff + CW'(1) == count_ff) ? S_WAIT : S_DUMP;
            end else begin
               raddr = idx_ff; have_in = 1'b1;
            end
         end
         S_MIN: begin
            // scan for smallest id above the last listed one
            if (have_ff) begin
               r = rd_data;
               if ((first_ff || r.id > low_ff) && (!best_ok_ff || r.id < best_ff.id)) begin
                  best_in = r; best_ok_in = 1'b1;
               end
            end
            if (idx_ff < count_ff) begin
               raddr = idx_ff; idx_in = idx_ff + CW'(1); have_in = 1'b1;
            end else if (have_ff) begin
               have_in = 1'b0;
            end else state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rd_in = mk(ST_OK, best_ff, occ, emitted_ff + CW'(1) == count_ff);
               emitted_in = emitted_ff + CW'(1); low_in = best_ff.id;
               first_in = 1'b0; best_ok_in = 1'b0; idx_in = '0;
               state_in = (emitted_ff + CW'(1) == count_ff) ? S_WAIT : S_MIN;
            end
         end
         S_WAIT: begin
            if (!rv_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && !(req.valid && !rv_ff)) best_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rv_ff <= 1'b0; have_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         have_ff <= have_in; best_ok_ff <= best_ok_in;
      end
      cmd_ff <= cmd_in; idx_ff <= idx_in; pos_ff <= pos_in; dst_ff <= dst_in;
      sorted_ff <= sorted_in; hold_ff <= hold_in; low_ff <= low_in;
      first_ff <= first_in; best_ff <= best_in; emitted_ff <= emitted_in;
      rd_ff <= rd_in;
   end
endmodule

>>> rtl/job_queue_table_engine_core.sv
// ----------------------------------------------------------------------------
// job_queue_table_engine_core
// ordered job queue with add, remove, modify, change, promote, sort and list
// ----------------------------------------------------------------------------
// req channel takes one command word; rsp channel returns result words, the
// final one of each command flagged by last.
// commands are handled one at a time; the store has one write port and one
// registered read port, and each command walks it entry by entry:
//   count, bad mode, empty cases: answered without touching the store
//   add, modify, change: id scan
//   remove: pop the head and shift the rest; promote: id scan plus shifts
//   reorder: insertion sort
//   display: one read per job; list: full min-id scan per job
// reset empties the queue; store contents need no clearing.
// a stalled receiver holds the result word; the engine waits for it and
// accepts no new command until the last result of the current one is taken.
// ----------------------------------------------------------------------------
module job_queue_table_engine_core import jqte_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input logic        clock,
   input logic        reset,
   jqte_req_if.sink   req,
   jqte_rsp_if.source rsp
);
   localparam int AW = $clog2(QUEUE_DEPTH);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   job_rec_type   wr_data;
   job_rec_type   rd_data;

   jqte_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
      .clock, .reset, .req, .rsp,
      .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   jqte_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
endmodule
